>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hdl/rfsc_pkg.sv
package rfsc_pkg;

  localparam int FRAME_BYTES = 12;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int MAP_BYTES   = 12;

  localparam logic [7:0] NEUTRAL_RST = 8'd150;
  localparam logic [6:0] LIMIT_RST   = 7'd100;
  localparam logic [7:0] START_RST   = 8'h9B;
  localparam logic [7:0] END_RST     = 8'h65;

  typedef enum logic [1:0] {
    CFG_NEUTRAL = 2'd0,
    CFG_LIMIT   = 2'd1,
    CFG_START   = 2'd2,
    CFG_END     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] neutral;
    logic [6:0] limit;
    logic [7:0] start_mark;
    logic [7:0] end_mark;
  } cfg_t;

  typedef logic [MAP_BYTES-1:0][7:0] frame_t;

endpackage

>>> hdl/rfsc_frame.sv
`include "assert_macros.svh"

module rfsc_frame (
  input  logic            clk,
  input  logic            rst,
  input  rfsc_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  output logic            snap_valid,
  input  logic            snap_take,
  output rfsc_pkg::frame_t snap
);
  import rfsc_pkg::*;

  logic             in_frame;
  logic [CNT_W-1:0] wr_index;
  logic [7:0]       store [FRAME_BYTES];
  frame_t           view;
  logic             acc;
  logic             is_start;
  logic             is_end;
  logic             frame_next;

  assign in_ready   = !snap_valid || snap_take;
  assign acc        = in_valid && in_ready;
  assign is_start   = (in_byte == cfg.start_mark);
  assign is_end     = (in_byte == cfg.end_mark);
  assign frame_next = in_frame || is_start;

  // bytes beyond the store read as zero
  for (genvar k = 0; k < MAP_BYTES; k++) begin : g_view
    if (k < FRAME_BYTES) begin : g_st
      assign view[k] = store[k];
    end else begin : g_zero
      assign view[k] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      wr_index <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) store[i] <= 8'd0;
    end else if (acc) begin
      if (is_end) begin
        in_frame <= 1'b0;
        wr_index <= '0;
      end else begin
        in_frame <= frame_next;
        if (frame_next && !is_start && wr_index < CNT_W'(FRAME_BYTES)) begin
          store[wr_index[IDX_W-1:0]] <= in_byte;
          wr_index <= wr_index + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (acc && is_end) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_end) snap <= view;
  end

  `ASSERT_IMPL(a_index_bound, clk, rst, 1'b1, wr_index <= CNT_W'(FRAME_BYTES))
  `ASSERT_NEXT(a_end_clears, clk, rst, acc && is_end, wr_index == '0 && !in_frame && snap_valid)
  `ASSERT_NEXT(a_snap_holds, clk, rst, snap_valid && !snap_take, snap_valid && $stable(snap))

endmodule

>>> hdl/rfsc_map.sv
`include "assert_macros.svh"

module rfsc_map (
  input  logic             clk,
  input  logic             rst,
  input  rfsc_pkg::cfg_t   cfg,
  input  logic             snap_valid,
  output logic             snap_take,
  input  rfsc_pkg::frame_t snap,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      out_data
);
  import rfsc_pkg::*;

  logic [1:0][7:0] held;
  logic [1:0][7:0] held_next;
  logic [63:0]     result;

  function automatic logic [7:0] clamp_u8(input logic signed [9:0] s);
    logic [7:0] r;
    if (s < 0) r = 8'd0;
    else if (s > 10'sd255) r = 8'd255;
    else r = s[7:0];
    return r;
  endfunction

  // positive: N - ceil(13v/20); negative: N + floor(7m/10), m = -v
  function automatic logic [7:0] steer_cmp(input logic [7:0] b, input logic [7:0] n,
                                           input logic [6:0] lim);
    logic [7:0]         mag;
    logic [10:0]        yp;
    logic [22:0]        pp;
    logic [9:0]         yn;
    logic [22:0]        pn;
    logic signed [9:0]  s;
    mag = 8'(~b + 8'd1);
    yp  = 11'({4'd0, b[6:0]} * 11'd13) + 11'd19;
    pp  = 23'(yp) * 23'd3277;
    yn  = 10'({2'd0, mag} * 10'd7);
    pn  = 23'(yn) * 23'd6554;
    if (!b[7] && b != 8'd0 && b[6:0] <= lim) begin
      s = $signed({2'b00, n}) - $signed({3'b000, pp[22:16]});
    end else if (b[7] && mag <= {1'b0, lim}) begin
      s = $signed({2'b00, n}) + $signed({3'b000, pn[22:16]});
    end else begin
      s = $signed({2'b00, n});
    end
    return clamp_u8(s);
  endfunction

  function automatic logic [7:0] drive_cmp(input logic [7:0] b, input logic [7:0] n,
                                           input logic [6:0] lim, input logic [7:0] hold);
    logic [7:0]        mag;
    logic signed [9:0] s;
    logic [7:0]        r;
    mag = 8'(~b + 8'd1);
    s   = $signed({2'b00, n}) + ($signed({{2{b[7]}}, b}) >>> 1);
    if (b == 8'd0) r = n;
    else if ((!b[7] && b[6:0] <= lim) || (b[7] && mag <= {1'b0, lim})) r = clamp_u8(s);
    else r = hold;
    return r;
  endfunction

  assign snap_take = snap_valid && (!out_valid || out_ready);

  always_comb begin
    held_next[0] = drive_cmp(snap[0], cfg.neutral, cfg.limit, held[0]);
    held_next[1] = drive_cmp(snap[2], cfg.neutral, cfg.limit, held[1]);
    result = {held_next[1], held_next[0],
              steer_cmp(snap[11], cfg.neutral, cfg.limit),
              steer_cmp(snap[9],  cfg.neutral, cfg.limit),
              steer_cmp(snap[7],  cfg.neutral, cfg.limit),
              steer_cmp(snap[5],  cfg.neutral, cfg.limit),
              steer_cmp(snap[3],  cfg.neutral, cfg.limit),
              steer_cmp(snap[1],  cfg.neutral, cfg.limit)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held      <= {NEUTRAL_RST, NEUTRAL_RST};
    end else if (snap_take) begin
      out_valid <= 1'b1;
      held      <= held_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) out_data <= result;
  end

  `ASSERT_NEXT(a_held_matches_out, clk, rst, snap_take, out_data[63:48] == held)
  `ASSERT_NEXT(a_held_stable, clk, rst, !snap_take, $stable(held))
  `ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

>>> hdl/rover_frame_to_servo_compare.sv
// Channel  Dir  Signals                       Contents
// s_axis   in   s_tvalid s_tready s_tdata     one received byte per request
// m_axis   out  m_tvalid m_tready m_tdata     eight 8-bit compare values per frame
// cfg      in   cfg_valid cfg_ready           cfg_index, cfg_data (one register)
//
// One byte per cycle while s_tready is high. An end byte is captured in the frame
// snapshot register, then passes through the compare maps into the output register.
// Reset (rst, synchronous) restores register defaults, clears the frame store
// and sets both held drives to 150. A stalled m_tready backs up into the snapshot
// stage; s_tready drops only while snapshot and output are full and m_tready is low.
module rover_frame_to_servo_compare (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // steer_front_left, steer_front_right, steer_mid_left,
                                 // steer_mid_right, steer_rear_left, steer_rear_right,
                                 // drive_first, drive_second (8 bits each, low first)
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import rfsc_pkg::*;

  cfg_t   cfg;
  logic   snap_valid;
  logic   snap_take;
  frame_t snap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.neutral    <= NEUTRAL_RST;
      cfg.limit      <= LIMIT_RST;
      cfg.start_mark <= START_RST;
      cfg.end_mark   <= END_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NEUTRAL: cfg.neutral    <= cfg_data;
        CFG_LIMIT:   cfg.limit      <= cfg_data[6:0];
        CFG_START:   cfg.start_mark <= cfg_data;
        CFG_END:     cfg.end_mark   <= cfg_data;
        default:     ;
      endcase
    end
  end

  rfsc_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .snap_valid (snap_valid),
    .snap_take  (snap_take),
    .snap       (snap)
  );

  rfsc_map u_map (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap_take  (snap_take),
    .snap       (snap),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule

>>> verif/tb_rover_frame_to_servo_compare.sv
module tb_rover_frame_to_servo_compare;
  import rfsc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS = 180;
  localparam int NUM_PHASES = 8;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  rover_frame_to_servo_compare DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor copy of the block
  logic [7:0] cur_neutral;
  logic [6:0] cur_limit;
  logic [7:0] cur_start;
  logic [7:0] cur_end;
  bit         pr_in_frame;
  int         pr_index;
  logic [7:0] frame_store [16];
  logic [7:0] held_drive [2];

  logic [63:0] pending_compares [$];
  logic [63:0] want_word;
  int          mismatches;
  int          items_sent;
  int          gap_pct;
  int          stall_pct;

  string field_names [8] = '{"steer_front_left", "steer_front_right", "steer_mid_left",
                             "steer_mid_right", "steer_rear_left", "steer_rear_right",
                             "drive_first", "drive_second"};

  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    logic [63:0] val;
  } dir_row_t;

  localparam logic [63:0] ALL_NEUTRAL = {8{8'd150}};

  // defaults: start 0x9B, end 0x65, neutral 150, limit 100
  dir_row_t dir_rows [23] = '{
    '{8'h65, 1'b1, ALL_NEUTRAL},   // end with no frame open
    '{8'h9B, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h65, 1'b1, ALL_NEUTRAL},   // all commands out of range, drives hold
    '{8'h9B, 1'b0, '0},
    '{8'd100, 1'b0, '0},
    '{8'd100, 1'b0, '0},
    '{8'h9B, 1'b0, '0},            // repeated start keeps the index
    '{8'h9C, 1'b0, '0},
    '{8'h9C, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'd120, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h55, 1'b0, '0},            // past the store, dropped
    '{8'hFF, 1'b0, '0},
    '{8'h65, 1'b0, '0}
  };

  task automatic log_mismatch(input string msg);
    if (mismatches < 100) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic int floor_div(input int a, input int d);
    int q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic logic [7:0] clamp8(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return 8'(x);
  endfunction

  function automatic logic [7:0] steer_compare(input logic [7:0] b);
    int v, n, lim;
    v = int'($signed(b));
    n = int'(cur_neutral);
    lim = int'(cur_limit);
    if (v >= 1 && v <= lim) return clamp8(floor_div(100 * n - 65 * v, 100));
    if (v <= -1 && v >= -lim) return clamp8(floor_div(10 * n - 7 * v, 10));
    return cur_neutral;
  endfunction

  function automatic logic [7:0] drive_compare(input logic [7:0] b, input int which);
    int v, n, lim;
    v = int'($signed(b));
    n = int'(cur_neutral);
    lim = int'(cur_limit);
    if (v == 0)
      held_drive[which] = cur_neutral;
    else if ((v >= 1 && v <= lim) || (v <= -1 && v >= -lim))
      held_drive[which] = clamp8(floor_div(2 * n + v, 2));
    return held_drive[which];
  endfunction

  // advances the predictor by one byte; returns 1 when a frame end emits
  function automatic bit frame_step(input logic [7:0] b, output logic [63:0] word);
    bit is_start, is_end;
    is_start = (b == cur_start);
    is_end = (b == cur_end);
    word = '0;
    if (is_start) pr_in_frame = 1'b1;
    if (is_end) begin
      pr_index = 0;
      pr_in_frame = 1'b0;
      for (int k = 0; k < 6; k++) word[k*8 +: 8] = steer_compare(frame_store[2*k + 1]);
      word[48 +: 8] = drive_compare(frame_store[0], 0);
      word[56 +: 8] = drive_compare(frame_store[2], 1);
      return 1'b1;
    end
    if (pr_in_frame && !is_start && pr_index < FRAME_BYTES) begin
      frame_store[pr_index] = b;
      pr_index++;
    end
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input logic [63:0] typed_val = '0);
    bit took;
    bit emits;
    logic [63:0] word;
    if ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    items_sent++;
    emits = frame_step(b, word);
    if (emits) pending_compares.push_back(typed ? typed_val : word);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    case (idx)
      CFG_NEUTRAL: cur_neutral = val;
      CFG_LIMIT:   cur_limit = val[6:0];
      CFG_START:   cur_start = val;
      CFG_END:     cur_end = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_compares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_command();
    int mag;
    mag = (cur_limit == 0) ? 1 : $urandom_range(int'(cur_limit), 1);
    case ($urandom_range(9))
      0: return 8'h00;
      1, 2: return 8'(mag);
      3, 4: return 8'(-mag);
      5: return 8'(cur_limit);
      6: return 8'(-int'(cur_limit));
      7: return ($urandom_range(1)) ? 8'(int'(cur_limit) + 1) : 8'(-int'(cur_limit) - 1);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(input int len, input int restart_at);
    send_byte(cur_start);
    for (int i = 0; i < len; i++) begin
      if (i == restart_at) send_byte(cur_start);
      send_byte(pick_command());
    end
    send_byte(cur_end);
  endtask

  task automatic run_random(input int budget);
    int sel, len;
    budget += items_sent;
    while (items_sent < budget) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        len = ($urandom_range(99) < 70) ? FRAME_BYTES : $urandom_range(FRAME_BYTES - 1, 0);
        send_frame(len, -1);
      end else if (sel < 87) begin
        len = $urandom_range(16, FRAME_BYTES - 2);
        send_frame(len, $urandom_range(len - 1, 0));
      end else begin
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(9))
            0: send_byte(cur_end);
            1: send_byte(cur_start);
            default: send_byte(8'($urandom_range(255)));
          endcase
        end
      end
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_compares.size() == 0) begin
        log_mismatch($sformatf("result %h with no frame end pending", m_tdata));
      end else begin
        want_word = pending_compares.pop_front();
        for (int f = 0; f < 8; f++) begin
          if (m_tdata[f*8 +: 8] !== want_word[f*8 +: 8])
            log_mismatch($sformatf("%s got %0d want %0d", field_names[f],
                                   m_tdata[f*8 +: 8], want_word[f*8 +: 8]));
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [7:0] nv, lv, sv, ev;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    m_tready  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_NEUTRAL;
    cfg_data  <= '0;
    mismatches = 0;
    items_sent = 0;
    gap_pct = 0;
    stall_pct = 0;
    cur_neutral = NEUTRAL_RST;
    cur_limit = LIMIT_RST;
    cur_start = START_RST;
    cur_end = END_RST;
    pr_in_frame = 1'b0;
    pr_index = 0;
    foreach (frame_store[i]) frame_store[i] = '0;
    held_drive[0] = 8'd150;
    held_drive[1] = 8'd150;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].val);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: begin nv = 8'd0;   lv = 8'd127; sv = 8'h00; ev = 8'hFF; end
          2: begin nv = 8'd255; lv = 8'd127; sv = 8'hFF; ev = 8'h00; end
          3: begin nv = 8'd128; lv = 8'd1;   sv = 8'h9B; ev = 8'h65; end
          4: begin nv = 8'd200; lv = 8'd0;   sv = 8'h10; ev = 8'h10; end // shared marker
          6: begin nv = NEUTRAL_RST; lv = 8'(LIMIT_RST); sv = START_RST; ev = END_RST; end
          default: begin
            nv = 8'($urandom_range(255));
            lv = 8'($urandom_range(127, 1));
            sv = 8'($urandom_range(255));
            ev = sv ^ 8'($urandom_range(255, 1));
          end
        endcase
        gap_pct = 0;
        s_tvalid <= 1'b0;
        wait_idle();
        write_reg(CFG_NEUTRAL, nv);
        write_reg(CFG_LIMIT, lv);
        write_reg(CFG_START, sv);
        write_reg(CFG_END, ev);
        cfg_valid <= 1'b0;
      end
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 47; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 47; end
        default: begin gap_pct = 24; stall_pct = 24; end
      endcase
      run_random((ph == 4) ? PHASE_ITEMS / 3 : PHASE_ITEMS);
    end

    s_tvalid <= 1'b0;
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
